### rtl/aafp_pkg.sv
package aafp_pkg;

  localparam int unsigned MaxDigits = 16;
  localparam int unsigned DigitCountWidth = 6;

  localparam logic [7:0] ChYawEnd   = 8'h3B;
  localparam logic [7:0] ChPitchEnd = 8'h25;
  localparam logic [7:0] ChStartA   = 8'h2A;
  localparam logic [7:0] ChStartB   = 8'h23;
  localparam logic [7:0] ChZero     = 8'h30;

  localparam logic [15:0] YawOffsetReset   = 16'd36000;
  localparam logic [15:0] PitchOffsetReset = 16'd18000;

  localparam int unsigned CfgAddrWidth = 3;

  typedef enum logic {
    REG_YAW_OFFSET   = 1'b0,
    REG_PITCH_OFFSET = 1'b1
  } reg_idx_t;

  typedef enum logic {
    AXIS_YAW   = 1'b0,
    AXIS_PITCH = 1'b1
  } axis_t;

  typedef struct packed {
    logic [15:0] yaw_offset;
    logic [15:0] pitch_offset;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               axis;
    logic signed [31:0] angle;
  } res_t;

endpackage

### rtl/aafp_cfg.sv
module aafp_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aafp_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output aafp_pkg::cfg_t                      cfg
);
  import aafp_pkg::*;

  logic [15:0] yaw_offset_r;
  logic [15:0] pitch_offset_r;
  logic        wr_en;
  reg_idx_t    idx;

  // Registers are word aligned; the low address bits do not select anything.
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_offset_r   <= YawOffsetReset;
      pitch_offset_r <= PitchOffsetReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_YAW_OFFSET:   yaw_offset_r   <= pwdata[15:0];
        REG_PITCH_OFFSET: pitch_offset_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_YAW_OFFSET:   prdata = {16'd0, yaw_offset_r};
      REG_PITCH_OFFSET: prdata = {16'd0, pitch_offset_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.yaw_offset   = yaw_offset_r;
  assign cfg.pitch_offset = pitch_offset_r;

endmodule

### rtl/aafp_parse.sv
module aafp_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           proc,
  input  logic [7:0]     rx_byte,
  input  logic           burst_start,
  input  aafp_pkg::cfg_t cfg,
  output aafp_pkg::res_t res
);
  import aafp_pkg::*;

  logic                       receiving_r, receiving_nxt;
  logic                       skip_r, skip_nxt;
  logic [DigitCountWidth-1:0] digit_count_r, digit_count_nxt;
  logic signed [31:0]         acc_r, acc_nxt;

  logic               skipping;
  logic               is_yaw_end;
  logic               is_pitch_end;
  logic               is_start;
  logic               do_fold;
  logic signed [8:0]  digit;
  logic signed [36:0] fold_sum;
  logic signed [31:0] fold_sat;
  logic signed [33:0] diff;
  logic signed [31:0] diff_sat;
  logic [15:0]        offset;

  assign is_yaw_end   = (rx_byte == ChYawEnd);
  assign is_pitch_end = (rx_byte == ChPitchEnd);
  assign is_start     = (rx_byte == ChStartA) || (rx_byte == ChStartB);
  assign skipping     = skip_r && !burst_start;
  assign do_fold      = receiving_r &&
                        (digit_count_r < DigitCountWidth'(MaxDigits));

  // value * 10 is formed as (value << 3) + (value << 1).
  assign digit    = $signed({1'b0, rx_byte}) - $signed({1'b0, ChZero});
  assign fold_sum = ($signed({{5{acc_r[31]}}, acc_r}) <<< 3) +
                    ($signed({{5{acc_r[31]}}, acc_r}) <<< 1) +
                    $signed({{28{digit[8]}}, digit});

  always_comb begin
    if (fold_sum[36:31] == 6'b000000 || fold_sum[36:31] == 6'b111111) begin
      fold_sat = fold_sum[31:0];
    end else if (fold_sum[36]) begin
      fold_sat = 32'sh8000_0000;
    end else begin
      fold_sat = 32'sh7FFF_FFFF;
    end
  end

  assign offset = is_pitch_end ? cfg.pitch_offset : cfg.yaw_offset;
  assign diff   = $signed({{2{acc_r[31]}}, acc_r}) - $signed({18'd0, offset});

  // Only the low side can overflow, since the offset is never negative.
  always_comb begin
    if (diff[33:31] == 3'b000 || diff[33:31] == 3'b111) begin
      diff_sat = diff[31:0];
    end else begin
      diff_sat = 32'sh8000_0000;
    end
  end

  always_comb begin
    receiving_nxt   = receiving_r;
    skip_nxt        = skip_r;
    digit_count_nxt = digit_count_r;
    acc_nxt         = acc_r;
    res.valid       = 1'b0;
    res.axis        = AXIS_YAW;
    res.angle       = diff_sat;
    if (proc) begin
      if (burst_start) begin
        skip_nxt = 1'b0;
      end
      if (!skipping) begin
        if (is_yaw_end || is_pitch_end) begin
          res.valid       = 1'b1;
          res.axis        = is_pitch_end ? AXIS_PITCH : AXIS_YAW;
          receiving_nxt   = 1'b0;
          digit_count_nxt = '0;
          acc_nxt         = '0;
          if (is_pitch_end) begin
            skip_nxt = 1'b1;
          end
        end else begin
          if (do_fold) begin
            acc_nxt         = fold_sat;
            digit_count_nxt = digit_count_r + 1'b1;
          end
          if (is_start) begin
            receiving_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r   <= 1'b0;
      skip_r        <= 1'b0;
      digit_count_r <= '0;
      acc_r         <= '0;
    end else begin
      receiving_r   <= receiving_nxt;
      skip_r        <= skip_nxt;
      digit_count_r <= digit_count_nxt;
      acc_r         <= acc_nxt;
    end
  end

  a_digit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    digit_count_r <= DigitCountWidth'(MaxDigits))
    else $error("digit count ran past its limit");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> (acc_r == 32'sd0) && (digit_count_r == '0) && !receiving_r)
    else $error("terminator did not clear the field state");

  a_pitch_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.axis == AXIS_PITCH) |=> skip_r)
    else $error("pitch terminator did not start skipping the burst");

  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (skip_r && !burst_start) |-> !res.valid)
    else $error("result produced inside a skipped burst");

endmodule

### rtl/ascii_angle_frame_parser_top.sv
// Serial angle frame parser. Each accepted byte is registered, then folded
// into the running field value; a ';' or '%' byte outside a skipped burst
// yields one yaw or pitch result, registered in the output register. A new
// byte is taken every clock cycle unless in_stall is high; multiply-by-ten
// and add are combinational, and in_stall rises only when out_stall holds
// a result in the output register and the registered byte is waiting. The
// user must write offsets through the APB port (yaw at 0x0, pitch at 0x4)
// while no request is in flight; the block itself does not enforce this.
module ascii_angle_frame_parser_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_rx_byte,
  input  logic                              in_burst_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_axis,
  output logic signed [31:0]                out_angle_centideg,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [aafp_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import aafp_pkg::*;

  cfg_t cfg;
  res_t res;

  logic               s1_valid_r, s1_valid_nxt;
  logic [7:0]         s1_byte_r;
  logic               s1_first_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_axis_r;
  logic signed [31:0] out_angle_r;
  logic               out_blocked;
  logic               accept;
  logic               proc;

  assign out_blocked = out_valid_r && out_stall;
  assign in_stall    = s1_valid_r && out_blocked;
  assign accept      = in_valid && !in_stall;
  assign proc        = s1_valid_r && !out_blocked;

  aafp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aafp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .proc        (proc),
    .rx_byte     (s1_byte_r),
    .burst_start (s1_first_r),
    .cfg         (cfg),
    .res         (res)
  );

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (proc) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r  <= in_rx_byte;
      s1_first_r <= in_burst_start;
    end
    if (res.valid) begin
      out_axis_r  <= res.axis;
      out_angle_r <= res.angle;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_axis           = out_axis_r;
  assign out_angle_centideg = out_angle_r;

  // A result may only be produced when the output register is free to take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !out_blocked)
    else $error("result overwrote a stalled output");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

  a_item_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_stall && !accept) |=> !s1_valid_r)
    else $error("registered byte was not processed");

endmodule
